[hdl/pmr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the paging mmu with random replacement
// no dependencies
package pmr_pkg;

   localparam int ADDR_W      = 32;
   localparam int SHIFT_W     = 5;
   localparam int NPAGES_W    = 11;
   localparam int NFRAMES_W   = 9;
   localparam int RND_W       = 8;
   localparam int CNT_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_DATA_W  = ADDR_W + RND_W;
   localparam int RSP_DATA_W  = ADDR_W + 5 * CNT_W;
   localparam int RSP_USER_W  = 3;

   // page table entry layout, frame number sits above these two bits
   localparam int PTE_PRESENT  = 0;
   localparam int PTE_MODIFIED = 1;

   // response flag positions in tuser
   localparam int FLAG_ILLEGAL   = 0;
   localparam int FLAG_FAULT     = 1;
   localparam int FLAG_WROTEBACK = 2;

   typedef struct packed {
      logic [NFRAMES_W-1:0] num_frames;
      logic [NPAGES_W-1:0]  num_pages;
      logic [SHIFT_W-1:0]   page_shift;
   } cfg_type;

endpackage

[hdl/pmr_ram.sv]
`timescale 1ns / 1ps
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
module pmr_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pmr_ctrl.sv]
`timescale 1ns / 1ps
// access sequencer: page lookup, fault handling, eviction, counters, result register
// depends on pmr_pkg; drives the page table and frame owner rams
module pmr_ctrl #(
   parameter int MAX_PAGES  = 1024,
   parameter int MAX_FRAMES = 256,
   parameter int PAGE_W     = 10,
   parameter int FRAME_W    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pmr_pkg::cfg_type                cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pmr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [pmr_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic [PAGE_W-1:0]               pt_rd_addr,
   output logic                            pt_wr_en,
   output logic [PAGE_W-1:0]               pt_wr_addr,
   output logic [FRAME_W+1:0]              pt_wr_data,
   input  logic [FRAME_W+1:0]              pt_rd_data,
   output logic [FRAME_W-1:0]              fo_rd_addr,
   output logic                            fo_wr_en,
   output logic [FRAME_W-1:0]              fo_wr_addr,
   output logic [PAGE_W-1:0]               fo_wr_data,
   input  logic [PAGE_W-1:0]               fo_rd_data
);

   localparam int AW     = pmr_pkg::ADDR_W;
   localparam int CW     = pmr_pkg::CNT_W;
   localparam int FREE_W = $clog2(MAX_FRAMES + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_EVICT = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [PAGE_W-1:0] clr_ff, clr_in;
   logic [FREE_W-1:0] next_free_ff, next_free_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [AW-1:0]     offset_ff, offset_in;
   logic [pmr_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic              legal_ff, legal_in;
   logic              write_ff, write_in;
   logic [FRAME_W-1:0] victim_ff, victim_in;
   logic              wb_ff, wb_in;
   logic [CW-1:0]     reads_ff, writes_ff, faults_ff, illegals_ff, wbacks_ff;
   logic [CW-1:0]     reads_in, writes_in, faults_in, illegals_in, wbacks_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [pmr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pmr_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [PAGE_W-1:0] pt_rd_addr_ff;

   logic [AW-1:0]     va;
   logic [AW-1:0]     page_full;
   logic [AW-1:0]     npages;
   logic [FREE_W-1:0] nframes;
   logic [AW-1:0]     victim_full;
   logic              accept;
   logic              rd_present, rd_modified;
   logic [FRAME_W-1:0] rd_frame;
   logic              free_ok;
   logic              done, fault;
   logic [FRAME_W-1:0] frame_sel;
   logic [AW-1:0]     phys;

   assign va = req_tdata[AW-1:0];

   // page number, legality bound and clamped victim frame for the incoming request
   always_comb begin
      page_full = va >> cfg.page_shift;
      if (AW'(cfg.num_pages) > AW'(MAX_PAGES)) begin
         npages = AW'(MAX_PAGES);
      end else begin
         npages = AW'(cfg.num_pages);
      end
      if (cfg.num_frames == '0) begin
         nframes = FREE_W'(1);
      end else if (AW'(cfg.num_frames) > AW'(MAX_FRAMES)) begin
         nframes = FREE_W'(MAX_FRAMES);
      end else begin
         nframes = FREE_W'(cfg.num_frames);
      end
      if (AW'(req_tdata[AW +: pmr_pkg::RND_W]) >= AW'(nframes)) begin
         victim_full = AW'(nframes) - AW'(1);
      end else begin
         victim_full = AW'(req_tdata[AW +: pmr_pkg::RND_W]);
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rd_present  = pt_rd_data[pmr_pkg::PTE_PRESENT];
   assign rd_modified = pt_rd_data[pmr_pkg::PTE_MODIFIED];
   assign rd_frame    = pt_rd_data[FRAME_W+1:2];
   assign free_ok     = next_free_ff < nframes;

   // frame owner read is issued with the page lookup, ahead of a possible eviction
   assign fo_rd_addr = victim_in;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_free_in = next_free_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      shift_in     = shift_ff;
      legal_in     = legal_ff;
      write_in     = write_ff;
      victim_in    = victim_ff;
      wb_in        = wb_ff;
      pt_rd_addr   = page_ff;
      pt_wr_en     = 1'b0;
      pt_wr_addr   = page_ff;
      pt_wr_data   = '0;
      fo_wr_en     = 1'b0;
      fo_wr_addr   = victim_ff;
      fo_wr_data   = page_ff;
      done         = 1'b0;
      fault        = 1'b0;
      frame_sel    = rd_frame;

      case (state_ff)
         ST_CLEAR: begin
            pt_wr_en   = 1'b1;
            pt_wr_addr = clr_ff;
            clr_in     = clr_ff + PAGE_W'(1);
            if (clr_ff == PAGE_W'(MAX_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pt_rd_addr = page_full[PAGE_W-1:0];
            if (accept) begin
               page_in   = page_full[PAGE_W-1:0];
               offset_in = va & ~({AW{1'b1}} << cfg.page_shift);
               shift_in  = cfg.page_shift;
               legal_in  = page_full < npages;
               write_in  = req_tuser;
               victim_in = victim_full[FRAME_W-1:0];
               wb_in     = 1'b0;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!legal_ff) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else if (rd_present) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               if (write_ff) begin
                  pt_wr_en   = 1'b1;
                  pt_wr_data = {rd_frame, 1'b1, 1'b1};
               end
            end else if (free_ok) begin
               // frames are never freed, so the next one in order is free
               done         = 1'b1;
               fault        = 1'b1;
               frame_sel    = next_free_ff[FRAME_W-1:0];
               next_free_in = next_free_ff + FREE_W'(1);
               pt_wr_en     = 1'b1;
               pt_wr_data   = {next_free_ff[FRAME_W-1:0], write_ff, 1'b1};
               fo_wr_en     = 1'b1;
               fo_wr_addr   = next_free_ff[FRAME_W-1:0];
               state_in     = ST_IDLE;
            end else begin
               // look up the page that owns the victim frame
               pt_rd_addr = fo_rd_data;
               page_in    = page_ff;
               state_in   = ST_EVICT;
            end
         end
         ST_EVICT: begin
            // the victim's entry, read in the lookup state, is on the read data; its address is held in pt_rd_addr_ff
            wb_in      = rd_modified;
            pt_wr_en   = 1'b1;
            pt_wr_addr = pt_rd_addr_ff;
            pt_wr_data = {rd_frame, rd_modified, 1'b0};
            state_in   = ST_FILL;
         end
         ST_FILL: begin
            done       = 1'b1;
            fault      = 1'b1;
            frame_sel  = victim_ff;
            pt_wr_en   = 1'b1;
            pt_wr_data = {victim_ff, write_ff, 1'b1};
            fo_wr_en   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // victim page address, held for the write that clears its present bit
   always_ff @(posedge clock) begin
      pt_rd_addr_ff <= pt_rd_addr;
   end

   assign phys = legal_ff ? ((AW'(frame_sel) << shift_ff) | offset_ff) : {AW{1'b1}};

   always_comb begin
      reads_in    = reads_ff    + CW'(done && legal_ff && !write_ff);
      writes_in   = writes_ff   + CW'(done && legal_ff && write_ff);
      faults_in   = faults_ff   + CW'(done && fault);
      illegals_in = illegals_ff + CW'(done && !legal_ff);
      wbacks_in   = wbacks_ff   + CW'(done && (state_ff == ST_FILL) && wb_ff);

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {wbacks_in, illegals_in, faults_in, writes_in, reads_in, phys};
         rsp_user_in[pmr_pkg::FLAG_ILLEGAL]   = !legal_ff;
         rsp_user_in[pmr_pkg::FLAG_FAULT]     = fault;
         rsp_user_in[pmr_pkg::FLAG_WROTEBACK] = (state_ff == ST_FILL) && wb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         faults_ff    <= '0;
         illegals_ff  <= '0;
         wbacks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         faults_ff    <= faults_in;
         illegals_ff  <= illegals_in;
         wbacks_ff    <= wbacks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      offset_ff   <= offset_in;
      shift_ff    <= shift_in;
      legal_ff    <= legal_in;
      write_ff    <= write_in;
      victim_ff   <= victim_in;
      wb_ff       <= wb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hdl/paging_mmu_random_replacement.sv]
`timescale 1ns / 1ps
// result: registered from the lookup state on a hit, an illegal access or a
//   fault that takes a free frame; from the fill state, after the evict state, when a fault evicts a victim
// accesses: one at a time, taken only in idle with the result register empty or being read out;
//   page table steps: lookup read, then read-modify-write, plus a victim read and clear on eviction
// reset: synchronous; then a clearing pass zeroes the page table entry by entry
//   with req_tready low; csr writes are taken throughout
module paging_mmu_random_replacement #(
   parameter int MAX_PAGES  = 1024,
   parameter int MAX_FRAMES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   // access request
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pmr_pkg::REQ_DATA_W-1:0]  req_tdata,  // virtual_address[31:0], random_frame[39:32]
   input  logic                            req_tuser,  // mode: 0 read, 1 write
   // access result
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // physical_address, read_count,
                                                       // write_count, fault_count,
                                                       // illegal_count, writeback_count
   output logic [pmr_pkg::RSP_USER_W-1:0]  rsp_tuser,  // illegal, page_fault, wrote_back
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmr_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PAGE_W  = $clog2(MAX_PAGES);
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PTE_W   = FRAME_W + 2;

   // register indexes on the csr channel
   localparam logic [pmr_pkg::CSR_IDX_W-1:0] CSR_PAGE_SHIFT = 2'd0;
   localparam logic [pmr_pkg::CSR_IDX_W-1:0] CSR_NUM_PAGES  = 2'd1;
   localparam logic [pmr_pkg::CSR_IDX_W-1:0] CSR_NUM_FRAMES = 2'd2;

   pmr_pkg::cfg_type cfg_ff, cfg_in;

   logic [PAGE_W-1:0]  pt_rd_addr, pt_wr_addr;
   logic               pt_wr_en;
   logic [PTE_W-1:0]   pt_wr_data, pt_rd_data;
   logic [FRAME_W-1:0] fo_rd_addr, fo_wr_addr;
   logic               fo_wr_en;
   logic [PAGE_W-1:0]  fo_wr_data, fo_rd_data;

   // configuration registers, always ready; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PAGE_SHIFT: cfg_in.page_shift = csr_data[pmr_pkg::SHIFT_W-1:0];
            CSR_NUM_PAGES:  cfg_in.num_pages  = csr_data[pmr_pkg::NPAGES_W-1:0];
            CSR_NUM_FRAMES: cfg_in.num_frames = csr_data[pmr_pkg::NFRAMES_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_shift <= pmr_pkg::SHIFT_W'(12);
         cfg_ff.num_pages  <= pmr_pkg::NPAGES_W'(1024);
         cfg_ff.num_frames <= pmr_pkg::NFRAMES_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer; only one access is in flight, so no page table read whose data is used
   // meets a pending write to the same entry
   pmr_ctrl #(
      .MAX_PAGES  (MAX_PAGES),
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_W     (PAGE_W),
      .FRAME_W    (FRAME_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .pt_rd_addr (pt_rd_addr),
      .pt_wr_en   (pt_wr_en),
      .pt_wr_addr (pt_wr_addr),
      .pt_wr_data (pt_wr_data),
      .pt_rd_data (pt_rd_data),
      .fo_rd_addr (fo_rd_addr),
      .fo_wr_en   (fo_wr_en),
      .fo_wr_addr (fo_wr_addr),
      .fo_wr_data (fo_wr_data),
      .fo_rd_data (fo_rd_data)
   );

   // page table: present, modified, frame per virtual page
   pmr_ram #(
      .DEPTH  (MAX_PAGES),
      .ADDR_W (PAGE_W),
      .DATA_W (PTE_W)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // frame owner: page held by each frame, written when the frame is handed out
   pmr_ram #(
      .DEPTH  (MAX_FRAMES),
      .ADDR_W (FRAME_W),
      .DATA_W (PAGE_W)
   ) u_frame_owner (
      .clock   (clock),
      .wr_en   (fo_wr_en),
      .wr_addr (fo_wr_addr),
      .wr_data (fo_wr_data),
      .rd_addr (fo_rd_addr),
      .rd_data (fo_rd_data)
   );

endmodule

[hdl/pmr_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the paging mmu, bound to the top level
// depends on pmr_pkg and paging_mmu_random_replacement
module pmr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pmr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [pmr_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   // reset starts the clearing pass with nothing pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   // one access in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while busy");

   // an illegal access neither faults nor writes back
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[pmr_pkg::FLAG_ILLEGAL] |->
         !rsp_tuser[pmr_pkg::FLAG_FAULT] && !rsp_tuser[pmr_pkg::FLAG_WROTEBACK])
      else $error("illegal access with fault or writeback flag");

   // a writeback only happens as part of a fault
   a_wb_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[pmr_pkg::FLAG_WROTEBACK] |-> rsp_tuser[pmr_pkg::FLAG_FAULT])
      else $error("writeback without page fault");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule

bind paging_mmu_random_replacement pmr_checker u_pmr_checker (.*);
